// File: rtl/vfat_long_name_assembler_macros.svh
// assertion macros shared by the long name assembler rtl
// depends on clk and rst_n being visible where the macros are used
`ifndef VFAT_LONG_NAME_ASSEMBLER_MACROS_SVH
`define VFAT_LONG_NAME_ASSEMBLER_MACROS_SVH

// same-cycle implication
`define LFN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfn assertion failed");

// next-cycle implication
`define LFN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfn assertion failed");

`endif

// File: rtl/lfn_pkg.sv
// shared types, constants and helpers for the long name assembler
// no dependencies
package lfn_pkg;

  localparam int unsigned LANES    = 13;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned ROW_BITS = LANES * UNIT_W;

  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_DELETED = 8'hE5;
  localparam logic [3:0] ATTR_LFN     = 4'hF;
  localparam logic [4:0] ORDER_MAX    = 5'd20;

  // byte offsets of the 13 name units inside a long-name piece
  localparam int unsigned LANE_OFF [LANES] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  typedef struct packed {
    logic              keep;
    logic [UNIT_W-1:0] unit;
  } lane_res_t;

  // one step of the short name rotate-add checksum
  function automatic logic [7:0] rot_add(input logic [7:0] s, input logic [7:0] b);
    rot_add = {s[0], s[7:1]} + b;
  endfunction

endpackage

// File: rtl/lfn_lane.sv
// one unit lane: drops filler units and clamped positions from a piece
// depends on lfn_pkg
module lfn_lane #(
  parameter int unsigned NAME_UNITS = 260,
  parameter int unsigned LANE       = 0
) (
  input  logic [15:0]        unit_i,
  input  logic [8:0]         row_base_i,
  output lfn_pkg::lane_res_t res_o
);
  import lfn_pkg::*;

  localparam logic [8:0] LIMIT = 9'(NAME_UNITS - 1);
  localparam logic [8:0] OFS   = 9'(LANE);

  logic [8:0] idx;

  assign idx        = row_base_i + OFS;
  assign res_o.unit = unit_i;
  assign res_o.keep = (unit_i != 16'h0000) && (unit_i != 16'hFFFF) && (idx < LIMIT);

endmodule

// File: rtl/lfn_merge.sv
// merges the lane results into one stored row of 13 units
// depends on lfn_pkg
module lfn_merge (
  input  logic [lfn_pkg::ROW_BITS-1:0] old_row_i,
  input  logic                         old_valid_i,
  input  lfn_pkg::lane_res_t           lanes_i [lfn_pkg::LANES],
  output logic [lfn_pkg::ROW_BITS-1:0] row_o
);
  import lfn_pkg::*;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (lanes_i[i].keep) begin
        row_o[i*UNIT_W +: UNIT_W] = lanes_i[i].unit;
      end else if (old_valid_i) begin
        row_o[i*UNIT_W +: UNIT_W] = old_row_i[i*UNIT_W +: UNIT_W];
      end else begin
        row_o[i*UNIT_W +: UNIT_W] = '0;
      end
    end
  end

endmodule

// File: rtl/lfn_utf8.sv
// utf-8 encoder for one utf-16 unit, surrogates not paired
// no dependencies beyond lfn_pkg widths
module lfn_utf8 (
  input  logic [lfn_pkg::UNIT_W-1:0] unit_i,
  output logic [23:0]                bytes_o,
  output logic [1:0]                 len_o
);
  import lfn_pkg::*;

  always_comb begin
    if (unit_i < 16'h0080) begin
      bytes_o = {16'h0000, unit_i[7:0]};
      len_o   = 2'd1;
    end else if (unit_i < 16'h0800) begin
      bytes_o = {8'h00, 2'b10, unit_i[5:0], 3'b110, unit_i[10:6]};
      len_o   = 2'd2;
    end else begin
      bytes_o = {2'b10, unit_i[5:0], 2'b10, unit_i[11:6], 4'hE, unit_i[15:12]};
      len_o   = 2'd3;
    end
  end

endmodule

// File: rtl/vfat_long_name_assembler.sv
// vfat long name assembler: top level with sequencer, unit store and output register
// depends on lfn_pkg, lfn_lane, lfn_merge, lfn_utf8 and the assertion macro header
//
// usage: one 32-byte directory entry per input item (in_valid / in_ready), results
// on the out_ channel (out_valid / out_ready). a restart item (in_kind = 1) clears
// all chain state and the end-of-scan flag. long-name pieces give no result; a
// stored piece passes accept, decode with row read, merged row write by 13 unit lanes.
// a short entry passes accept, decode and the checksum steps SUM1 and SUM2 before its
// first result; a raw short name is one result. a long name streams one unit per
// cycle through the utf-8 encoder unless a result waits on a stalled receiver, with
// a store read before each row of 13 units; a result leaves every UNITS_PER_RESULT units.
// in_ready is high only while the sequencer is idle; a finished result sits in the
// output register, so the next item is taken while it waits. a stalled receiver
// holds the sequencer only when it has a further result to hand over.
// reset clears the chain flags, the end-of-scan flag and the row valid bits, so the
// store reads as empty at once without a clearing pass.
module vfat_long_name_assembler #(
  parameter int unsigned NAME_UNITS       = 260,
  parameter int unsigned OUTPUT_BYTES     = 768,
  parameter int unsigned UNITS_PER_RESULT = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_entry_bytes_0_7,
  input  logic [63:0] in_entry_bytes_8_15,
  input  logic [63:0] in_entry_bytes_16_23,
  input  logic [63:0] in_entry_bytes_24_31,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_name_is_long,
  output logic [63:0] out_text_low,
  output logic [55:0] out_text_high,
  output logic [3:0]  out_byte_count,
  output logic [7:0]  out_entry_attr,
  output logic [31:0] out_file_size,
  output logic        out_last
);
  import lfn_pkg::*;
  `include "vfat_long_name_assembler_macros.svh"

  localparam int unsigned ROWS   = (NAME_UNITS + LANES - 1) / LANES;
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned N_W    = $clog2(NAME_UNITS + 1);
  localparam int unsigned OPOS_W = $clog2(OUTPUT_BYTES + 4);
  localparam int unsigned GU_W   = $clog2(UNITS_PER_RESULT + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_PWRITE = 4'd2;
  localparam logic [3:0] ST_SUM1   = 4'd3;
  localparam logic [3:0] ST_SUM2   = 4'd4;
  localparam logic [3:0] ST_SHORT  = 4'd5;
  localparam logic [3:0] ST_CRD    = 4'd6;
  localparam logic [3:0] ST_CUNIT  = 4'd7;

  // control state
  logic [3:0]      state_r, state_nxt;
  logic            scan_ended_r, scan_ended_nxt;
  logic            chain_active_r, chain_active_nxt;
  logic            chain_valid_r, chain_valid_nxt;
  logic [7:0]      csum_r, csum_nxt;
  logic [ROWS-1:0] vld_r, vld_nxt;
  logic            out_valid_r, out_valid_nxt;

  // payload and working registers
  logic            kind_r, kind_nxt;
  logic [255:0]    entry_r, entry_nxt;
  logic [7:0]      psum_r, psum_nxt;
  logic [N_W-1:0]  n_r, n_nxt;
  logic [4:0]      crow_r, crow_nxt;
  logic [3:0]      ccol_r, ccol_nxt;
  logic [OPOS_W-1:0] opos_r, opos_nxt;
  logic [119:0]    gbuf_r, gbuf_nxt;
  logic [3:0]      gbytes_r, gbytes_nxt;
  logic [GU_W-1:0] gunits_r, gunits_nxt;
  logic            o_long_r, o_long_nxt;
  logic [119:0]    o_text_r, o_text_nxt;
  logic [3:0]      o_cnt_r, o_cnt_nxt;
  logic            o_last_r, o_last_nxt;
  logic [7:0]      o_attr_r, o_attr_nxt;
  logic [31:0]     o_size_r, o_size_nxt;

  // unit store: one row of 13 units per order number
  logic [ROW_BITS-1:0] mem_r [ROWS];
  logic [ROW_BITS-1:0] rd_data_r;
  logic                mem_re, mem_we;
  logic [ROW_W-1:0]    mem_raddr;
  logic [ROW_BITS-1:0] mem_wdata;

  // entry fields
  logic [7:0]  first_b, attr_b, piece_sum;
  logic [4:0]  order, prow;
  logic [ROW_W-1:0] prow_idx, crow_idx;
  logic        prow_in, crow_in;
  logic [8:0]  row_base;
  logic [31:0] fsize;

  lane_res_t   lane_res [LANES];

  // conversion path
  logic [15:0] cunit;
  logic [23:0] enc_bytes;
  logic [1:0]  enc_len;
  logic        term, full, out_free;
  logic [7:0]  s_full;

  assign first_b   = entry_r[7:0];
  assign attr_b    = entry_r[95:88];
  assign piece_sum = entry_r[111:104];
  assign fsize     = entry_r[255:224];
  assign order     = first_b[4:0];
  assign prow      = order - 5'd1;
  assign prow_in   = 32'(prow) < ROWS;
  assign prow_idx  = prow[ROW_W-1:0];
  assign row_base  = 9'(prow) * 9'd13;
  assign crow_in   = 32'(crow_r) < ROWS;
  assign crow_idx  = crow_r[ROW_W-1:0];
  assign out_free  = !out_valid_r || out_ready;

  // 13 lanes filter the piece units in parallel
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lfn_lane #(.NAME_UNITS(NAME_UNITS), .LANE(i)) u_lane (
      .unit_i     (entry_r[LANE_OFF[i]*8 +: 16]),
      .row_base_i (row_base),
      .res_o      (lane_res[i])
    );
  end

  // merge with the old row contents, an invalid row counts as empty
  lfn_merge u_merge (
    .old_row_i   (rd_data_r),
    .old_valid_i (vld_r[prow_idx]),
    .lanes_i     (lane_res),
    .row_o       (mem_wdata)
  );

  assign cunit = (crow_in && vld_r[crow_idx]) ? rd_data_r[{ccol_r, 4'b0000} +: 16] : 16'h0000;

  lfn_utf8 u_utf8 (
    .unit_i  (cunit),
    .bytes_o (enc_bytes),
    .len_o   (enc_len)
  );

  assign term = (n_r >= N_W'(NAME_UNITS)) || (cunit == 16'h0000) ||
                ((OPOS_W+1)'(opos_r) + (OPOS_W+1)'(4) >= (OPOS_W+1)'(OUTPUT_BYTES));
  assign full = gunits_r == GU_W'(UNITS_PER_RESULT);

  // checksum over name bytes 6..10 on top of the partial sum
  always_comb begin
    s_full = psum_r;
    for (int k = 6; k < 11; k++) begin
      s_full = rot_add(s_full, entry_r[k*8 +: 8]);
    end
  end

  assign mem_raddr = (state_r == ST_DECODE) ? prow_idx : crow_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[prow_idx] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem_r[mem_raddr];
    end
  end

  always_comb begin
    state_nxt        = state_r;
    scan_ended_nxt   = scan_ended_r;
    chain_active_nxt = chain_active_r;
    chain_valid_nxt  = chain_valid_r;
    csum_nxt         = csum_r;
    vld_nxt          = vld_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    kind_nxt         = kind_r;
    entry_nxt        = entry_r;
    psum_nxt         = psum_r;
    n_nxt            = n_r;
    crow_nxt         = crow_r;
    ccol_nxt         = ccol_r;
    opos_nxt         = opos_r;
    gbuf_nxt         = gbuf_r;
    gbytes_nxt       = gbytes_r;
    gunits_nxt       = gunits_r;
    o_long_nxt       = o_long_r;
    o_text_nxt       = o_text_r;
    o_cnt_nxt        = o_cnt_r;
    o_last_nxt       = o_last_r;
    o_attr_nxt       = o_attr_r;
    o_size_nxt       = o_size_r;
    mem_re           = 1'b0;
    mem_we           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          entry_nxt = {in_entry_bytes_24_31, in_entry_bytes_16_23,
                       in_entry_bytes_8_15, in_entry_bytes_0_7};
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (kind_r) begin
          // restart: drop chain and end-of-scan
          vld_nxt          = '0;
          csum_nxt         = '0;
          chain_active_nxt = 1'b0;
          chain_valid_nxt  = 1'b0;
          scan_ended_nxt   = 1'b0;
        end else if (scan_ended_r) begin
          state_nxt = ST_IDLE;
        end else if (first_b == BYTE_END) begin
          scan_ended_nxt = 1'b1;
        end else if (attr_b[3:0] == ATTR_LFN) begin
          if (order == 5'd0 || order > ORDER_MAX) begin
            chain_active_nxt = 1'b0;
          end else if (first_b[6] || chain_active_r) begin
            if (first_b[6]) begin
              // fresh chain
              vld_nxt          = '0;
              chain_active_nxt = 1'b1;
              chain_valid_nxt  = 1'b1;
              csum_nxt         = piece_sum;
            end else if (piece_sum != csum_r) begin
              chain_valid_nxt = 1'b0;
            end
            if (prow_in) begin
              mem_re    = 1'b1;
              state_nxt = ST_PWRITE;
            end
          end
        end else if (first_b == BYTE_DELETED) begin
          vld_nxt          = '0;
          csum_nxt         = '0;
          chain_active_nxt = 1'b0;
          chain_valid_nxt  = 1'b0;
        end else begin
          psum_nxt = '0;
          for (int k = 0; k < 6; k++) begin
            psum_nxt = rot_add(psum_nxt, entry_r[k*8 +: 8]);
          end
          state_nxt = ST_SUM1;
        end
      end
      ST_PWRITE: begin
        mem_we            = 1'b1;
        vld_nxt[prow_idx] = 1'b1;
        state_nxt         = ST_IDLE;
      end
      ST_SUM1: begin
        state_nxt = ST_SUM2;
      end
      ST_SUM2: begin
        if (chain_active_r && chain_valid_r && (s_full == csum_r)) begin
          n_nxt      = '0;
          crow_nxt   = '0;
          ccol_nxt   = '0;
          opos_nxt   = '0;
          gbuf_nxt   = '0;
          gbytes_nxt = '0;
          gunits_nxt = '0;
          state_nxt  = ST_CRD;
        end else begin
          state_nxt = ST_SHORT;
        end
      end
      ST_SHORT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          o_long_nxt       = 1'b0;
          o_text_nxt       = {32'h0, entry_r[87:0]};
          o_cnt_nxt        = 4'd11;
          o_last_nxt       = 1'b1;
          o_attr_nxt       = attr_b;
          o_size_nxt       = fsize;
          vld_nxt          = '0;
          csum_nxt         = '0;
          chain_active_nxt = 1'b0;
          chain_valid_nxt  = 1'b0;
          state_nxt        = ST_IDLE;
        end
      end
      ST_CRD: begin
        mem_re    = crow_in;
        state_nxt = ST_CUNIT;
      end
      ST_CUNIT: begin
        if (!((term || full) && !out_free)) begin
          if (term) begin
            out_valid_nxt    = 1'b1;
            o_long_nxt       = 1'b1;
            o_text_nxt       = gbuf_r;
            o_cnt_nxt        = gbytes_r;
            o_last_nxt       = 1'b1;
            o_attr_nxt       = attr_b;
            o_size_nxt       = fsize;
            vld_nxt          = '0;
            csum_nxt         = '0;
            chain_active_nxt = 1'b0;
            chain_valid_nxt  = 1'b0;
            state_nxt        = ST_IDLE;
          end else begin
            if (full) begin
              // group is full and another unit follows
              out_valid_nxt = 1'b1;
              o_long_nxt    = 1'b1;
              o_text_nxt    = gbuf_r;
              o_cnt_nxt     = gbytes_r;
              o_last_nxt    = 1'b0;
              o_attr_nxt    = attr_b;
              o_size_nxt    = fsize;
              gbuf_nxt      = 120'(enc_bytes);
              gbytes_nxt    = 4'(enc_len);
              gunits_nxt    = GU_W'(1);
            end else begin
              gbuf_nxt   = gbuf_r | (120'(enc_bytes) << {gbytes_r, 3'b000});
              gbytes_nxt = gbytes_r + 4'(enc_len);
              gunits_nxt = gunits_r + GU_W'(1);
            end
            opos_nxt = opos_r + OPOS_W'(enc_len);
            n_nxt    = n_r + N_W'(1);
            if (ccol_r == 4'd12) begin
              ccol_nxt  = '0;
              crow_nxt  = crow_r + 5'd1;
              state_nxt = ST_CRD;
            end else begin
              ccol_nxt = ccol_r + 4'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      scan_ended_r   <= 1'b0;
      chain_active_r <= 1'b0;
      chain_valid_r  <= 1'b0;
      csum_r         <= '0;
      vld_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      scan_ended_r   <= scan_ended_nxt;
      chain_active_r <= chain_active_nxt;
      chain_valid_r  <= chain_valid_nxt;
      csum_r         <= csum_nxt;
      vld_r          <= vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    entry_r  <= entry_nxt;
    psum_r   <= psum_nxt;
    n_r      <= n_nxt;
    crow_r   <= crow_nxt;
    ccol_r   <= ccol_nxt;
    opos_r   <= opos_nxt;
    gbuf_r   <= gbuf_nxt;
    gbytes_r <= gbytes_nxt;
    gunits_r <= gunits_nxt;
    o_long_r <= o_long_nxt;
    o_text_r <= o_text_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
    o_attr_r <= o_attr_nxt;
    o_size_r <= o_size_nxt;
  end

  assign in_ready         = state_r == ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_name_is_long = o_long_r;
  assign out_text_low     = o_text_r[63:0];
  assign out_text_high    = o_text_r[119:64];
  assign out_byte_count   = o_cnt_r;
  assign out_entry_attr   = o_attr_r;
  assign out_file_size    = o_size_r;
  assign out_last         = o_last_r;

  // raw short names always carry eleven bytes
  `LFN_ASSERT_NOW(a_short_count, out_valid && !out_name_is_long, out_byte_count == 4'd11)
  // a long result that is not the final one holds text
  `LFN_ASSERT_NOW(a_mid_nonempty, out_valid && out_name_is_long && !out_last,
                  out_byte_count != 4'd0)
  // a restart leaves no chain and no end-of-scan flag
  `LFN_ASSERT_NEXT(a_restart_clear, state_r == ST_DECODE && kind_r,
                   !scan_ended_r && !chain_active_r && vld_r == '0)

endmodule
